// ===== rtl/core/assert_macros.svh =====
// assertion macros used by the filter rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge out of reset
`define ASSERT_ALWAYS(label, expr) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("%m: assertion failed");

// consequent holds at the edge after the antecedent
`define ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("%m: assertion failed");

`endif

// ===== rtl/core/ldiir_pkg.sv =====
// package with widths, register indexes and types of the loudness filter
package ldiir_pkg;

	localparam int MANTISSA_BITS = 28;
	localparam int SAMPLE_W      = 32;
	localparam int OUT_W         = 29;
	localparam int ACC_W         = 64;
	localparam int NUM_REGS      = 6;
	localparam int REG_IDX_W     = $clog2(NUM_REGS);

	typedef logic signed [SAMPLE_W-1:0] smp_t;
	typedef logic signed [ACC_W-1:0]    acc_t;
	typedef logic [REG_IDX_W-1:0]       reg_idx_t;
	typedef logic [1:0]                 step_t;

	localparam reg_idx_t REG_S1_B0  = reg_idx_t'(0);
	localparam reg_idx_t REG_S1_B1  = reg_idx_t'(1);
	localparam reg_idx_t REG_S1_A1M = reg_idx_t'(2);
	localparam reg_idx_t REG_S2_B0  = reg_idx_t'(3);
	localparam reg_idx_t REG_S2_B1  = reg_idx_t'(4);
	localparam reg_idx_t REG_S2_A1M = reg_idx_t'(5);

	localparam smp_t COEF_ONE       = smp_t'(64'sd1 <<< MANTISSA_BITS);
	localparam smp_t COEF_MINUS_ONE = smp_t'(-(64'sd1 <<< MANTISSA_BITS));

	localparam acc_t SAT_POS = acc_t'((64'sd1 <<< (2 * MANTISSA_BITS)) - 64'sd1);
	localparam acc_t SAT_NEG = acc_t'(-((64'sd1 <<< (2 * MANTISSA_BITS)) - 64'sd1));

	localparam step_t STEP_X     = 2'd0;
	localparam step_t STEP_XPREV = 2'd1;
	localparam step_t STEP_YPREV = 2'd2;
	localparam step_t STEP_LAST  = 2'd3;

endpackage

// ===== rtl/core/loudness_two_stage_iir_filter.sv =====
// two cascaded first-order reintegrating iir sections on one shared mac
//
//  channel | handshake            | payload
//  --------+----------------------+-----------------------------
//  in      | in_valid / in_ready  | sample_in  (32 bit signed)
//  out     | out_valid / out_ready| sample_out (29 bit signed)
//  cfg     | cfg_we               | cfg_index, cfg_data (32 bit)
//
// each sample passes the accept cycle, the x, xprev, yprev and last steps of each section on the
// single 32x32 multiplier and 64 bit accumulator, and the saturate cycle.
// in_ready is high only while the sequencer is idle; a finished result waits
// in the output register, so the next sample can be taken meanwhile.
// the saturate cycle stalls while an earlier result has not been transferred.
// reset clears coefficients to their defaults and all filter history to zero.
`include "assert_macros.svh"

module loudness_two_stage_iir_filter
	import ldiir_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic signed [SAMPLE_W-1:0] sample_in,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic signed [OUT_W-1:0]    sample_out,
	input  logic                       cfg_we,
	input  logic [REG_IDX_W-1:0]       cfg_index,
	input  logic [SAMPLE_W-1:0]        cfg_data
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_MAC  = 2'd1;
	localparam logic [1:0] ST_SAT  = 2'd2;

	logic [1:0] state_q;
	step_t      step_q;
	logic       sec_q;

	smp_t coef_q [NUM_REGS];

	smp_t x1_q;
	acc_t prod_q;
	acc_t acc_q;

	smp_t s1_prev_in_q, s1_prev_out_q;
	smp_t s2_prev_in_q, s2_prev_out_q;
	acc_t s1_acc_q, s2_acc_q;

	logic                    out_valid_q;
	logic signed [OUT_W-1:0] out_data_q;

	smp_t mul_a, mul_c;
	acc_t mul_p;
	acc_t acc_sum, acc_sat, acc_shift_1, acc_shift_2;
	smp_t y2;
	logic in_xfer, out_free, sat_fire;

	assign in_ready   = (state_q == ST_IDLE);
	assign in_xfer    = in_valid && in_ready;
	assign out_free   = !out_valid_q || out_ready;
	assign sat_fire   = (state_q == ST_SAT) && out_free;
	assign out_valid  = out_valid_q;
	assign sample_out = out_data_q;

	// operand select for the shared multiplier
	always_comb begin
		unique case (step_q)
			STEP_X: begin
				mul_a = sec_q ? s1_prev_out_q : x1_q;
				mul_c = sec_q ? coef_q[REG_S2_B0] : coef_q[REG_S1_B0];
			end
			STEP_XPREV: begin
				mul_a = sec_q ? s2_prev_in_q : s1_prev_in_q;
				mul_c = sec_q ? coef_q[REG_S2_B1] : coef_q[REG_S1_B1];
			end
			default: begin
				mul_a = sec_q ? s2_prev_out_q : s1_prev_out_q;
				mul_c = sec_q ? coef_q[REG_S2_A1M] : coef_q[REG_S1_A1M];
			end
		endcase
	end

	// signed 32x32 product, full 64 bit result
	assign mul_p = mul_a * mul_c;

	assign acc_sum     = acc_q + prod_q;
	assign acc_shift_1 = acc_sum >>> MANTISSA_BITS;

	// saturation of section two
	always_comb begin
		priority if (acc_q >= SAT_POS) begin
			acc_sat = SAT_POS;
		end else if (acc_q < SAT_NEG) begin
			acc_sat = SAT_NEG;
		end else begin
			acc_sat = acc_q;
		end
	end

	assign acc_shift_2 = acc_sat >>> MANTISSA_BITS;
	assign y2          = acc_shift_2[SAMPLE_W-1:0];

	// coefficient registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q[REG_S1_B0]  <= COEF_ONE;
			coef_q[REG_S1_B1]  <= '0;
			coef_q[REG_S1_A1M] <= COEF_MINUS_ONE;
			coef_q[REG_S2_B0]  <= COEF_ONE;
			coef_q[REG_S2_B1]  <= '0;
			coef_q[REG_S2_A1M] <= COEF_MINUS_ONE;
		end else if (cfg_we && (int'(cfg_index) < NUM_REGS)) begin
			coef_q[cfg_index] <= cfg_data;
		end
	end

	// sequencer and filter history
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			step_q        <= STEP_X;
			sec_q         <= 1'b0;
			s1_prev_in_q  <= '0;
			s1_prev_out_q <= '0;
			s2_prev_in_q  <= '0;
			s2_prev_out_q <= '0;
			s1_acc_q      <= '0;
			s2_acc_q      <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						state_q <= ST_MAC;
						step_q  <= STEP_X;
						sec_q   <= 1'b0;
					end
				end
				ST_MAC: begin
					if (step_q == STEP_LAST) begin
						step_q <= STEP_X;
						if (!sec_q) begin
							s1_acc_q      <= acc_sum;
							s1_prev_in_q  <= x1_q;
							s1_prev_out_q <= acc_shift_1[SAMPLE_W-1:0];
							sec_q         <= 1'b1;
						end else begin
							state_q <= ST_SAT;
						end
					end else begin
						step_q <= step_q + 2'd1;
					end
				end
				ST_SAT: begin
					if (out_free) begin
						s2_acc_q      <= acc_sat;
						s2_prev_in_q  <= s1_prev_out_q;
						s2_prev_out_q <= y2;
						state_q       <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath: multiplier register and accumulator
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			x1_q  <= smp_t'(sample_in >>> (SAMPLE_W - MANTISSA_BITS));
			acc_q <= s1_acc_q;
		end else if (state_q == ST_MAC) begin
			if (step_q != STEP_LAST) begin
				prod_q <= mul_p;
			end
			if (step_q == STEP_LAST && !sec_q) begin
				acc_q <= s2_acc_q;
			end else if (step_q != STEP_X) begin
				acc_q <= acc_sum;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (sat_fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (sat_fire) begin
			out_data_q <= y2[OUT_W-1:0];
		end
	end

	`ASSERT_NEXT(a_accept_starts_mac, in_xfer, (state_q == ST_MAC) && (step_q == STEP_X) && !sec_q)
	`ASSERT_NEXT(a_sat_gives_result, sat_fire, out_valid_q && (state_q == ST_IDLE))
	`ASSERT_ALWAYS(a_step_idle, (state_q == ST_MAC) || (step_q == STEP_X))

endmodule

// ===== tb/testbench.sv =====
// testbench for the two-stage loudness iir filter: directed table, then random traffic
`timescale 1ns / 100ps

module testbench;
	import ldiir_pkg::*;

	typedef enum logic [1:0] {ROW_WRITE, ROW_KNOWN, ROW_PREDICT} row_kind_t;

	typedef struct packed {
		row_kind_t        kind;
		reg_idx_t         idx;
		smp_t             value;
		logic [OUT_W-1:0] known_out;
	} stim_row_t;

	localparam int       DIRECTED_ROWS  = 40;
	localparam int       RAND_PER_PHASE = 317;
	localparam int       RETUNE_EVERY   = 80;
	localparam int       DRAIN_CYCLES   = 16;
	localparam int       STALL_LIMIT    = 4000;
	localparam int       MAX_GAP        = 40;
	localparam reg_idx_t REG_UNUSED_LO  = reg_idx_t'(NUM_REGS);
	localparam reg_idx_t REG_UNUSED_HI  = '1;
	localparam acc_t     ACC_LIMIT      = (acc_t'(1) <<< (2 * MANTISSA_BITS)) - acc_t'(1);

	localparam int SEND_IDLE [3] = '{27, 67, 0};
	localparam int RECV_IDLE [3] = '{67, 27, 0};

	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                in_valid  = 1'b0;
	logic                in_ready;
	smp_t                sample_in = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic signed [OUT_W-1:0] sample_out;
	logic                cfg_we    = 1'b0;
	reg_idx_t            cfg_index = '0;
	logic [SAMPLE_W-1:0] cfg_data  = '0;

	// filter state as the block should hold it
	smp_t coef_regs [NUM_REGS];
	acc_t s1_accum, s2_accum;
	smp_t s1_prev_in, s1_prev_out, s2_prev_in, s2_prev_out;

	logic [OUT_W-1:0] pending_out_q [$];
	logic [OUT_W-1:0] want_out;
	smp_t walk_level     = '0;
	int   send_idle_pct  = 0;
	int   recv_idle_pct  = 0;
	int   mismatch_count = 0;
	int   results_seen   = 0;
	int   samples_sent   = 0;
	int   settings_count = 1;
	int   clip_count     = 0;
	int   stall_cycles   = 0;

	stim_row_t directed_rows [DIRECTED_ROWS] = '{
		'{ROW_KNOWN,   '0,            32'h7FFF_FFFF, 29'h07FF_FFFF},
		'{ROW_KNOWN,   '0,            32'h8000_0000, 29'h1800_0000},
		'{ROW_KNOWN,   '0,            32'h0000_0000, 29'h0000_0000},
		'{ROW_KNOWN,   '0,            32'hFFFF_FFFF, 29'h1FFF_FFFF},
		'{ROW_KNOWN,   '0,            32'h0000_000F, 29'h0000_0000},
		'{ROW_KNOWN,   '0,            32'h0000_0010, 29'h0000_0001},
		'{ROW_KNOWN,   '0,            32'hFFFF_FFF0, 29'h1FFF_FFFF},
		'{ROW_KNOWN,   '0,            32'hFFFF_FFEF, 29'h1FFF_FFFE},
		'{ROW_KNOWN,   '0,            32'h5555_5555, 29'h0555_5555},
		'{ROW_KNOWN,   '0,            32'hAAAA_AAAA, 29'h1AAA_AAAA},
		// writes past the last register must leave the identity filter alone
		'{ROW_WRITE,   REG_UNUSED_LO, 32'h0000_0000, '0},
		'{ROW_WRITE,   REG_UNUSED_HI, 32'hFFFF_FFFF, '0},
		'{ROW_KNOWN,   '0,            32'h1234_5670, 29'h0123_4567},
		'{ROW_WRITE,   REG_S1_B0,     32'h7FFF_FFFF, '0},
		'{ROW_WRITE,   REG_S1_B1,     32'h7FFF_FFFF, '0},
		'{ROW_WRITE,   REG_S1_A1M,    32'h7FFF_FFFF, '0},
		'{ROW_WRITE,   REG_S2_B0,     32'h7FFF_FFFF, '0},
		'{ROW_WRITE,   REG_S2_B1,     32'h7FFF_FFFF, '0},
		'{ROW_WRITE,   REG_S2_A1M,    32'h7FFF_FFFF, '0},
		'{ROW_PREDICT, '0,            32'h7FFF_FFFF, '0},
		'{ROW_PREDICT, '0,            32'h7FFF_FFFF, '0},
		'{ROW_PREDICT, '0,            32'h8000_0000, '0},
		'{ROW_PREDICT, '0,            32'h0000_0000, '0},
		'{ROW_WRITE,   REG_S1_B0,     32'h8000_0000, '0},
		'{ROW_WRITE,   REG_S1_B1,     32'h8000_0000, '0},
		'{ROW_WRITE,   REG_S1_A1M,    32'h8000_0000, '0},
		'{ROW_WRITE,   REG_S2_B0,     32'h8000_0000, '0},
		'{ROW_WRITE,   REG_S2_B1,     32'h8000_0000, '0},
		'{ROW_WRITE,   REG_S2_A1M,    32'h8000_0000, '0},
		'{ROW_PREDICT, '0,            32'h8000_0000, '0},
		'{ROW_PREDICT, '0,            32'h7FFF_FFFF, '0},
		'{ROW_PREDICT, '0,            32'hFFFF_FFFF, '0},
		'{ROW_WRITE,   REG_S1_B0,     32'h0000_0000, '0},
		'{ROW_WRITE,   REG_S1_B1,     32'h0000_0000, '0},
		'{ROW_WRITE,   REG_S1_A1M,    32'h0000_0000, '0},
		'{ROW_WRITE,   REG_S2_B0,     32'h0000_0000, '0},
		'{ROW_WRITE,   REG_S2_B1,     32'h0000_0000, '0},
		'{ROW_WRITE,   REG_S2_A1M,    32'h0000_0000, '0},
		'{ROW_PREDICT, '0,            32'h7FFF_FFFF, '0},
		'{ROW_PREDICT, '0,            32'h8000_0000, '0}
	};

	loudness_two_stage_iir_filter dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.sample_in  (sample_in),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.sample_out (sample_out),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	always #1 clk = ~clk;

	function automatic acc_t section_mac(input acc_t acc, input smp_t x, input smp_t x_prev,
		input smp_t y_prev, input smp_t b0, input smp_t b1, input smp_t a1m);
		return acc + acc_t'(x) * acc_t'(b0) + acc_t'(x_prev) * acc_t'(b1)
			+ acc_t'(y_prev) * acc_t'(a1m);
	endfunction

	function automatic logic [OUT_W-1:0] next_filtered(input smp_t smp);
		smp_t x1, y1, y2;
		acc_t a1, a2;
		x1 = smp >>> (SAMPLE_W - MANTISSA_BITS);
		a1 = section_mac(s1_accum, x1, s1_prev_in, s1_prev_out,
			coef_regs[REG_S1_B0], coef_regs[REG_S1_B1], coef_regs[REG_S1_A1M]);
		y1 = smp_t'(a1 >>> MANTISSA_BITS);
		a2 = section_mac(s2_accum, y1, s2_prev_in, s2_prev_out,
			coef_regs[REG_S2_B0], coef_regs[REG_S2_B1], coef_regs[REG_S2_A1M]);
		if (a2 >= ACC_LIMIT) begin
			a2 = ACC_LIMIT;
			clip_count++;
		end else if (a2 < -ACC_LIMIT) begin
			a2 = -ACC_LIMIT;
			clip_count++;
		end
		y2 = smp_t'(a2 >>> MANTISSA_BITS);
		s1_accum    = a1;
		s1_prev_in  = x1;
		s1_prev_out = y1;
		s2_accum    = a2;
		s2_prev_in  = y1;
		s2_prev_out = y2;
		return y2[OUT_W-1:0];
	endfunction

	function automatic smp_t pick_sample();
		case ($urandom_range(9))
			0, 1, 2, 3: return smp_t'($urandom);
			4: begin
				case ($urandom_range(5))
					0: return 32'h7FFF_FFFF;
					1: return 32'h8000_0000;
					2: return 32'h0000_0000;
					3: return 32'hFFFF_FFFF;
					4: return 32'h0000_0010;
					default: return 32'hFFFF_FFF0;
				endcase
			end
			5, 6: return smp_t'($urandom) >>> $urandom_range(31, 8);
			default: begin
				walk_level = walk_level + smp_t'(int'($urandom_range(1 << 24, 0)) - (1 << 23));
				return walk_level;
			end
		endcase
	endfunction

	task automatic flag_mismatch(input string what, input logic [OUT_W-1:0] want,
		input logic [OUT_W-1:0] got);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("mismatch, %s: expected %h, got %h", what, want, got);
	endtask

	task automatic write_reg(input reg_idx_t idx, input smp_t val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx < NUM_REGS)
			coef_regs[idx] = val;
		@(posedge clk);
	endtask

	// hold off input until every result is out and the sequencer has gone quiet
	task automatic drain_filter();
		in_valid <= 1'b0;
		while (pending_out_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic send_sample(input smp_t smp, input bit use_known,
		input logic [OUT_W-1:0] known_out);
		logic [OUT_W-1:0] predicted;
		int gap;
		gap = 0;
		while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct)
			gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		sample_in <= smp;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		predicted = next_filtered(smp);
		pending_out_q.push_back(use_known ? known_out : predicted);
		samples_sent++;
	endtask

	task automatic retune_filter();
		int style;
		reg_idx_t idx;
		smp_t val;
		style = $urandom_range(3);
		drain_filter();
		for (int i = 0; i < NUM_REGS; i++) begin
			idx = reg_idx_t'(i);
			if (style < 2) begin
				if (idx == REG_S1_B0 || idx == REG_S2_B0)
					val = smp_t'($urandom_range(32'h2000_0000, 0));
				else if (idx == REG_S1_B1 || idx == REG_S2_B1)
					val = smp_t'($urandom_range(32'h2000_0000, 0)) - COEF_ONE;
				else
					val = -smp_t'($urandom_range(32'h1000_0000, 0));
			end else if (style == 2) begin
				val = smp_t'($urandom);
			end else begin
				case ($urandom_range(5))
					0: val = 32'h8000_0000;
					1: val = 32'h7FFF_FFFF;
					2: val = 32'h0000_0000;
					3: val = COEF_ONE;
					4: val = COEF_MINUS_ONE;
					default: val = smp_t'($urandom);
				endcase
			end
			if ($urandom_range(9) < 8)
				write_reg(idx, val);
		end
		if ($urandom_range(3) == 0)
			write_reg(reg_idx_t'($urandom_range(REG_UNUSED_HI, REG_UNUSED_LO)), smp_t'($urandom));
		settings_count++;
	endtask

	// output side: check each transfer against the oldest pending sample
	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			results_seen++;
			if (pending_out_q.size() == 0) begin
				flag_mismatch("result with no sample pending", '0, sample_out);
			end else begin
				want_out = pending_out_q.pop_front();
				if (sample_out !== want_out)
					flag_mismatch("sample_out", want_out, sample_out);
			end
		end
		out_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	initial begin
		while (stall_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				stall_cycles = 0;
			else
				stall_cycles++;
		end
		$display("timeout: no transfer for %0d cycles", STALL_LIMIT);
		$display("testbench failed");
		$finish;
	end

	initial begin
		coef_regs[REG_S1_B0]  = COEF_ONE;
		coef_regs[REG_S1_B1]  = '0;
		coef_regs[REG_S1_A1M] = COEF_MINUS_ONE;
		coef_regs[REG_S2_B0]  = COEF_ONE;
		coef_regs[REG_S2_B1]  = '0;
		coef_regs[REG_S2_A1M] = COEF_MINUS_ONE;
		s1_accum    = '0;
		s2_accum    = '0;
		s1_prev_in  = '0;
		s1_prev_out = '0;
		s2_prev_in  = '0;
		s2_prev_out = '0;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[r]) begin
			case (directed_rows[r].kind)
				ROW_WRITE: begin
					if (in_valid)
						drain_filter();
					write_reg(directed_rows[r].idx, directed_rows[r].value);
				end
				ROW_KNOWN: send_sample(directed_rows[r].value, 1'b1, directed_rows[r].known_out);
				default: send_sample(directed_rows[r].value, 1'b0, '0);
			endcase
		end
		settings_count += 3;

		for (int ph = 0; ph < 3; ph++) begin
			send_idle_pct = SEND_IDLE[ph];
			recv_idle_pct = RECV_IDLE[ph];
			for (int n = 0; n < RAND_PER_PHASE; n++) begin
				if (n % RETUNE_EVERY == 0)
					retune_filter();
				else if ($urandom_range(149) == 0)
					drain_filter();
				send_sample(pick_sample(), 1'b0, '0);
			end
		end

		drain_filter();
		$display("%0d samples sent, %0d results checked, over %0d coefficient settings",
			samples_sent, results_seen, settings_count);
		$display("%0d samples clipped in stage two, %0d mismatches", clip_count, mismatch_count);
		if (mismatch_count == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/ldiir_pkg.sv
rtl/core/loudness_two_stage_iir_filter.sv
tb/testbench.sv
